FILE: src/ttt_pkg.sv
// shared types, constants and helpers for the timed task table
// used by timed_task_table; no dependencies
`timescale 1ns / 1ps

package ttt_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int TIME_W        = 32;
   localparam int TAG_W         = 8;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int RES_W         = $clog2(MAX_RESULTS + 1);
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_AT    = 2'd0,
      KIND_EVERY = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_FIRED    = 2'd2,
      STAT_NONE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_PROC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] due;
      logic [TIME_W-1:0] period;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // add that sticks at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

FILE: src/ttt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ttt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/timed_task_table.sv
// timed task table top level: request decode, table walk and result register
// depends on ttt_pkg and ttt_ram
`timescale 1ns / 1ps

// usage
//   req channel: one transfer per request. tuser selects the request kind
//   (insert at an absolute time, insert periodic, tick); tdata carries the
//   time, the repeat period and the task tag.
//   rsp channel: results in order; tuser is the status, tdata the fired tag,
//   tlast closes the results of one request.
// request handling
//   inserts, empty ticks and unknown kinds: the exec state writes the single
//   result into the result register once it is free; a new request is taken
//   only in idle. tick: the walk reads one entry a cycle from the table ram,
//   unless held by a full result register, and writes it back compacted in place.
//   a tick reports at most MAX_RESULTS fired entries.
// reset
//   synchronous, clears the fill count, state, result valid and pending flag;
//   the table ram needs no clearing since only entries below the count are read.
// stalls
//   one result register holds a finished transfer while the next request is
//   accepted; while it is full and not taken, the walk waits on a fired tag.
module timed_task_table
   import ttt_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*TIME_W+TAG_W-1:0]     req_tdata,   // time_value, repeat_period, task_tag
   input  logic [KIND_W-1:0]             req_tuser,   // kind
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [TAG_W-1:0]              rsp_tdata,   // fired_tag
   output logic [STATUS_W-1:0]           rsp_tuser,   // status
   output logic                          rsp_tlast
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // fsm and captured request
   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  per_ff, per_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;

   // table bookkeeping
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;      // read position of the walk
   logic [CNT_W-1:0]   wptr_ff, wptr_in;    // compacted write position
   logic [RES_W-1:0]   fired_ff, fired_in;
   logic               pend_ff, pend_in;    // a fired tag waits for its last flag
   logic [TAG_W-1:0]   pend_tag_ff, pend_tag_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_last_ff, rsp_last_in;

   // ram ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_ent;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_ent;

   logic               slot_free;
   logic               fire;
   logic [CNT_W-1:0]   idx_next;
   logic               last_entry;

   ttt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS),
      .ADDR_W(IDX_W)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_ent     = entry_type'(rd_data);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign idx_next   = idx_ff + 1'b1;
   assign last_entry = (idx_next == count_ff);
   assign fire       = (fired_ff < RES_W'(MAX_RESULTS)) && (now_ff >= rd_ent.due);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      kind_ff       <= kind_in;
      now_ff        <= now_in;
      per_ff        <= per_in;
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      wptr_ff       <= wptr_in;
      fired_ff      <= fired_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      per_in        = per_ff;
      tag_in        = tag_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wptr_in       = wptr_ff;
      fired_in      = fired_ff;
      pend_in       = pend_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_ent        = '{due: now_ff, period: '0, tag: tag_ff};
      rd_addr       = idx_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_tuser;
               now_in   = req_tdata[TIME_W-1:0];
               per_in   = req_tdata[2*TIME_W-1:TIME_W];
               tag_in   = req_tdata[2*TIME_W+TAG_W-1:2*TIME_W];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            idx_in   = '0;
            wptr_in  = '0;
            fired_in = '0;
            pend_in  = 1'b0;
            if ((kind_ff == KIND_TICK) && (count_ff != '0)) begin
               state_in = ST_READ;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               case (kind_ff)
                  KIND_AT, KIND_EVERY: begin
                     if (count_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_INSERTED;
                        wr_en         = 1'b1;
                        if (kind_ff == KIND_EVERY) begin
                           wr_ent = '{due: sat_add(now_ff, per_ff), period: per_ff,
                                      tag: tag_ff};
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     // empty tick or unknown kind
                     rsp_status_in = STAT_NONE;
                  end
               endcase
            end
         end

         ST_READ: begin
            // ram address of the first entry is on the port this cycle
            state_in = ST_PROC;
         end

         ST_PROC: begin
            // a second fired tag needs the result slot for the held one
            if (!(fire && pend_ff && !slot_free)) begin
               if (!(fire && (rd_ent.period == '0))) begin
                  wr_en   = 1'b1;
                  wr_addr = wptr_ff[IDX_W-1:0];
                  wr_ent  = rd_ent;
                  if (fire) begin
                     wr_ent.due = sat_add(rd_ent.due, rd_ent.period);
                  end
                  wptr_in = wptr_ff + 1'b1;
               end
               if (fire) begin
                  fired_in    = fired_ff + 1'b1;
                  pend_in     = 1'b1;
                  pend_tag_in = rd_ent.tag;
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_FIRED;
                     rsp_tag_in    = pend_tag_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
               idx_in = idx_next;
               if (last_entry) begin
                  state_in = ST_FIN;
               end else begin
                  rd_addr = idx_next[IDX_W-1:0];
               end
            end
         end

         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_status_in = pend_ff ? STAT_FIRED : STAT_NONE;
               rsp_tag_in    = pend_ff ? pend_tag_ff : '0;
               pend_in       = 1'b0;
               count_in      = wptr_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_tag_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
